// ----- design/ray_box_slab_test_unit_defines.svh -----
// ----------------------------------------------------------------------------
// ray box slab test unit assertion macros
// property forms used by the slab test unit
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_UNIT_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define RBST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbst assertion failed");

// next-cycle implication, active during reset as well
`define RBST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rbst assertion failed");

`endif

// ----- design/rbst_pkg.sv -----
// ----------------------------------------------------------------------------
// rbst_pkg
// shared constants for the ray box slab test unit
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_AXES       = 3;
  localparam int NUM_IN_FIELDS  = 4 * NUM_AXES;

endpackage

// ----- design/ray_box_slab_test_unit.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// fixed point ray against axis-aligned box slab test, three axis lanes
//
//   channel   dir   beat contents
//   s_axis    in    origin xyz, dir xyz, box low xyz, box high xyz
//   m_axis    out   hit, t_enter, t_exit
//
// one test per cycle unless the output stalls; the pipeline depth is mostly
// the restoring dividers, one quotient bit per stage in each lane
// the whole pipeline holds while the output beat is not taken
// rst clears only the valid tracking; no clearing pass
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit
  import rbst_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IW = ((NUM_IN_FIELDS * COORD_BITS + 7) / 8) * 8,
  localparam int OW = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z
  input  logic [IW-1:0] s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // hit, t_enter, t_exit, zero fill
  output logic [OW-1:0] m_tdata
);

  `include "ray_box_slab_test_unit_defines.svh"

  localparam int CB  = COORD_BITS;
  localparam int LAT = CB + FRAC_BITS + 7;

  logic en;
  logic [LAT-1:0] vld;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  logic signed [CB-1:0] lane_min [NUM_AXES];
  logic signed [CB-1:0] lane_max [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbst_axis_lane #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk      (clk),
      .en       (en),
      .origin   (s_tdata[a * CB +: CB]),
      .dir      (s_tdata[(NUM_AXES + a) * CB +: CB]),
      .box_low  (s_tdata[(2 * NUM_AXES + a) * CB +: CB]),
      .box_high (s_tdata[(3 * NUM_AXES + a) * CB +: CB]),
      .tmin     (lane_min[a]),
      .tmax     (lane_max[a])
    );
  end

  // merge: largest minimum, smallest maximum
  logic signed [CB-1:0] enter, leave;
  logic signed [CB-1:0] e01, l01;

  assign e01 = (lane_min[1] > lane_min[0]) ? lane_min[1] : lane_min[0];
  assign l01 = (lane_max[1] < lane_max[0]) ? lane_max[1] : lane_max[0];

  always_ff @(posedge clk) begin
    if (en) begin
      enter <= (lane_min[2] > e01) ? lane_min[2] : e01;
      leave <= (lane_max[2] < l01) ? lane_max[2] : l01;
    end
  end

  logic                 out_hit;
  logic signed [CB-1:0] out_enter, out_exit;

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit   <= !leave[CB-1] && (leave >= enter);
      out_enter <= enter;
      out_exit  <= leave;
    end
  end

  assign m_tdata = OW'({out_exit, out_enter, out_hit});

  `RBST_ASSERT_IMPL(a_hit_order, m_tvalid && out_hit, (out_exit >= out_enter) && !out_exit[CB-1])
  `RBST_ASSERT_IMPL(a_miss_order, m_tvalid && !out_hit, out_exit[CB-1] || (out_exit < out_enter))
  `RBST_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid)

endmodule

// ----- design/rbst_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rbst_div_pipe
// unsigned restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module rbst_div_pipe #(
  parameter int NB = 49,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NB-1:0] quotient
);

  logic [DW-1:0] rem_q [NB-1];
  logic [NB-1:0] quo_q [NB];
  logic [DW-1:0] div_q [NB-1];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [NB-1:0] q_in;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = dividend;
      assign d_in = divisor;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = div_q[k-1];
    end

    // quotient bits shift in at the bottom as dividend bits leave the top
    assign t  = {r_in, q_in[NB-1]};
    assign ge = t >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[k] <= {q_in[NB-2:0], ge};
      end
    end

    // the last stage keeps only its quotient
    if (k < NB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
          div_q[k] <= d_in;
        end
      end
    end
  end

  assign quotient = quo_q[NB-1];

endmodule

// ----- design/rbst_axis_lane.sv -----
// ----------------------------------------------------------------------------
// rbst_axis_lane
// one axis of the slab test: two slab distances, saturation, ordering
// ----------------------------------------------------------------------------
module rbst_axis_lane
  import rbst_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] origin,
  input  logic signed [COORD_BITS-1:0] dir,
  input  logic signed [COORD_BITS-1:0] box_low,
  input  logic signed [COORD_BITS-1:0] box_high,
  output logic signed [COORD_BITS-1:0] tmin,
  output logic signed [COORD_BITS-1:0] tmax
);

  localparam int CB = COORD_BITS;
  localparam int NW = CB + 1;
  localparam int NB = CB + 1 + FRAC_BITS;
  localparam logic signed [CB-1:0] INF     = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] NEG_INF = {1'b1, {(CB-1){1'b0}}};
  localparam logic [NB-1:0] SIGN_MAG = NB'(1) << (CB - 1);

  // slab numerators and direction
  logic signed [NW-1:0] dn1, dn2;
  logic signed [CB-1:0] dd;

  always_ff @(posedge clk) begin
    if (en) begin
      dn1 <= $signed({box_low[CB-1], box_low})   - $signed({origin[CB-1], origin});
      dn2 <= $signed({box_high[CB-1], box_high}) - $signed({origin[CB-1], origin});
      dd  <= dir;
    end
  end

  // magnitudes and sign flags
  logic [NW-1:0] an1, an2;
  logic [CB-1:0] ad;
  logic [3:0]    flags;   // neg1, neg2, zero direction, origin inside slab

  always_ff @(posedge clk) begin
    if (en) begin
      an1   <= dn1[NW-1] ? NW'(-dn1) : NW'(dn1);
      an2   <= dn2[NW-1] ? NW'(-dn2) : NW'(dn2);
      ad    <= dd[CB-1] ? CB'(-dd) : CB'(dd);
      flags <= {dn1[NW-1] ^ dd[CB-1], dn2[NW-1] ^ dd[CB-1], dd == '0,
                (dn1 <= 0) && (dn2 >= 0)};
    end
  end

  logic [NB-1:0] q1, q2;

  rbst_div_pipe #(.NB(NB), .DW(CB)) u_div_low (
    .clk      (clk),
    .en       (en),
    .dividend ({an1, {FRAC_BITS{1'b0}}}),
    .divisor  (ad),
    .quotient (q1)
  );

  rbst_div_pipe #(.NB(NB), .DW(CB)) u_div_high (
    .clk      (clk),
    .en       (en),
    .dividend ({an2, {FRAC_BITS{1'b0}}}),
    .divisor  (ad),
    .quotient (q2)
  );

  // flags ride alongside the divider stages
  logic [3:0] flag_dly [NB];

  always_ff @(posedge clk) begin
    if (en) begin
      flag_dly[0] <= flags;
      for (int k = 1; k < NB; k++) begin
        flag_dly[k] <= flag_dly[k-1];
      end
    end
  end

  // saturate and apply sign
  logic signed [CB-1:0] s1, s2;
  logic [1:0]           zf;

  always_ff @(posedge clk) begin
    if (en) begin
      if (flag_dly[NB-1][3]) begin
        s1 <= (q1 > SIGN_MAG) ? NEG_INF : CB'(NB'(0) - q1);
      end else begin
        s1 <= (q1 > SIGN_MAG - NB'(1)) ? INF : q1[CB-1:0];
      end
      if (flag_dly[NB-1][2]) begin
        s2 <= (q2 > SIGN_MAG) ? NEG_INF : CB'(NB'(0) - q2);
      end else begin
        s2 <= (q2 > SIGN_MAG - NB'(1)) ? INF : q2[CB-1:0];
      end
      zf <= flag_dly[NB-1][1:0];
    end
  end

  // order the pair, zero direction gives everything or nothing
  always_ff @(posedge clk) begin
    if (en) begin
      if (zf[1]) begin
        tmin <= zf[0] ? NEG_INF : INF;
        tmax <= zf[0] ? INF : NEG_INF;
      end else begin
        tmin <= (s1 < s2) ? s1 : s2;
        tmax <= (s1 < s2) ? s2 : s1;
      end
    end
  end

endmodule

// ----- tb/sv/slab_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slab_checker
// watches both stream channels of the slab test unit, works out the hit and
// the entry and exit distances of every accepted ray and box, and compares
// them with the result beats in order
// ----------------------------------------------------------------------------
module slab_checker
  import rbst_pkg::*;
#(
  parameter int CB = 32,
  parameter int FB = 16,
  parameter int IW = 384,
  parameter int OW = 72
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tready,
  input  logic [IW-1:0] s_tdata,
  input  logic          m_tvalid,
  input  logic          m_tready,
  input  logic [OW-1:0] m_tdata,
  output int            fail_count,
  output int            pending,
  output int            hits_seen,
  output int            results_seen
);

  localparam logic signed [63:0] POS_INF = (64'sd1 <<< (CB - 1)) - 1;
  localparam logic signed [63:0] NEG_INF = -POS_INF - 1;

  typedef struct packed {
    logic        hit;
    logic [CB-1:0] t_enter;
    logic [CB-1:0] t_exit;
  } slab_result_t;

  slab_result_t expected_q[$];

  function automatic logic signed [63:0] coord(input logic [IW-1:0] d, input int idx);
    logic [CB-1:0] v;
    v = d[idx*CB +: CB];
    return 64'(signed'(v));
  endfunction

  // exact quotient (num << FB) / den truncated toward zero, then saturated
  function automatic logic signed [63:0] slab_quot(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
    logic signed [127:0] n, q;
    n = 128'(num) <<< FB;
    q = n / 128'(den);
    if (q > 128'(POS_INF)) return POS_INF;
    if (q < 128'(NEG_INF)) return NEG_INF;
    return 64'(q);
  endfunction

  function automatic slab_result_t predict_slab(input logic [IW-1:0] d);
    logic signed [63:0] o, dr, lo, hi, t1, t2, mn, mx, enter, leave;
    slab_result_t r;
    enter = NEG_INF;
    leave = POS_INF;
    for (int a = 0; a < NUM_AXES; a++) begin
      o  = coord(d, a);
      dr = coord(d, 3 + a);
      lo = coord(d, 6 + a);
      hi = coord(d, 9 + a);
      if (dr == 0) begin
        if (lo <= o && o <= hi) begin
          mn = NEG_INF; mx = POS_INF;
        end else begin
          mn = POS_INF; mx = NEG_INF;
        end
      end else begin
        t1 = slab_quot(lo - o, dr);
        t2 = slab_quot(hi - o, dr);
        mn = (t1 < t2) ? t1 : t2;
        mx = (t1 < t2) ? t2 : t1;
      end
      if (mn > enter) enter = mn;
      if (mx < leave) leave = mx;
    end
    r.hit = (leave >= 0) && (leave >= enter);
    r.t_enter = enter[CB-1:0];
    r.t_exit = leave[CB-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    slab_result_t got, want;
    if (rst) begin
      fail_count <= 0;
      hits_seen <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_q.insert(expected_q.size(), predict_slab(s_tdata));
      if (m_tvalid && m_tready) begin
        // hit in the lowest bit, then t_enter, then t_exit
        got.hit = m_tdata[0];
        got.t_enter = m_tdata[1 +: CB];
        got.t_exit = m_tdata[1 + CB +: CB];
        results_seen <= results_seen + 1;
        hits_seen <= hits_seen + got.hit;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected hit %0b enter %h exit %h, got hit %0b enter %h exit %h",
                       want.hit, want.t_enter, want.t_exit,
                       got.hit, got.t_enter, got.t_exit);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives rays and boxes into the slab test unit with random gaps and output
// stalls; the checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module testbench;
  import rbst_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int IW = ((NUM_IN_FIELDS * CB + 7) / 8) * 8;
  localparam int OW = ((2 * CB + 1 + 7) / 8) * 8;
  localparam int LATENCY = CB + FB + 7;
  localparam int N_RANDOM = 1300;
  localparam int QUIET_TAIL = 200;
  localparam int IDLE_LIMIT = 4000;

  localparam logic [CB-1:0] MAX_C = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] MIN_C = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] ONE_C = CB'(1) << FB;

  logic          clk, rst;
  logic          s_tvalid, s_tready;
  logic [IW-1:0] s_tdata;
  logic          m_tvalid, m_tready;
  logic [OW-1:0] m_tdata;
  int            fail_count, pending, hits_seen, results_seen;
  int            idle_cycles;
  bit            quiet;

  ray_box_slab_test_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  slab_checker #(.CB(CB), .FB(FB), .IW(IW), .OW(OW)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending),
    .hits_seen(hits_seen), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    m_tready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        m_tready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 12);
        m_tready <= 1;
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return {$urandom()};
      1: return MAX_C;
      2: return MIN_C;
      3: return '0;
      default: return CB'(signed'($urandom_range(0, 40 << FB)) - (20 << FB));
    endcase
  endfunction

  function automatic logic [CB-1:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {$urandom()};
      2: return CB'($urandom_range(1, 15));
      3: return -CB'($urandom_range(1, 15));
      default: return CB'(signed'($urandom_range(0, 4 << FB)) - (2 << FB));
    endcase
  endfunction

  // mostly a sane box around random centres, sometimes inverted or junk
  function automatic logic [IW-1:0] rand_beat();
    logic [IW-1:0] d;
    logic signed [CB-1:0] c, h;
    d = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      d[a*CB +: CB] = rand_coord();
      d[(3+a)*CB +: CB] = rand_dir();
      if ($urandom_range(0, 4) == 0) begin
        d[(6+a)*CB +: CB] = {$urandom()};
        d[(9+a)*CB +: CB] = {$urandom()};
      end else begin
        c = signed'($urandom_range(0, 20 << FB)) - (10 << FB);
        h = $urandom_range(0, 4 << FB);
        d[(6+a)*CB +: CB] = c - h;
        d[(9+a)*CB +: CB] = c + h;
      end
    end
    return d;
  endfunction

  function automatic logic [IW-1:0] pack_ray(
    input logic [CB-1:0] ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz);
    return IW'({hz, hy, hx, lz, ly, lx, dz, dy, dx, oz, oy, ox});
  endfunction

  task automatic send_beat(input logic [IW-1:0] d);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      s_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    logic [IW-1:0] directed[$];
    int waited;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    quiet = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // plain hit, miss, ray starting inside, box behind
    directed.insert(directed.size(), pack_ray(0, 0, 0, ONE_C, ONE_C, ONE_C,
                    ONE_C, ONE_C, ONE_C, 2*ONE_C, 2*ONE_C, 2*ONE_C));
    directed.insert(directed.size(), pack_ray(0, 0, 0, ONE_C, -ONE_C, ONE_C,
                    ONE_C, ONE_C, ONE_C, 2*ONE_C, 2*ONE_C, 2*ONE_C));
    directed.insert(directed.size(), pack_ray(0, 0, 0, -ONE_C, ONE_C, ONE_C,
                    -ONE_C, -ONE_C, -ONE_C, ONE_C, ONE_C, ONE_C));
    directed.insert(directed.size(), pack_ray(0, 0, 0, ONE_C, ONE_C, ONE_C,
                    -2*ONE_C, -2*ONE_C, -2*ONE_C, -ONE_C, -ONE_C, -ONE_C));
    // zero direction, origin on an edge, inside and outside
    directed.insert(directed.size(), pack_ray(ONE_C, 0, 0, 0, ONE_C, ONE_C,
                    ONE_C, -ONE_C, -ONE_C, 2*ONE_C, ONE_C, ONE_C));
    directed.insert(directed.size(), pack_ray(2*ONE_C, 0, 0, 0, 0, ONE_C,
                    ONE_C, -ONE_C, -ONE_C, 2*ONE_C, ONE_C, ONE_C));
    directed.insert(directed.size(), pack_ray(3*ONE_C, 0, 0, 0, ONE_C, ONE_C,
                    ONE_C, -ONE_C, -ONE_C, 2*ONE_C, ONE_C, ONE_C));
    directed.insert(directed.size(), pack_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // inverted box
    directed.insert(directed.size(), pack_ray(0, 0, 0, ONE_C, ONE_C, -ONE_C,
                    2*ONE_C, 2*ONE_C, -ONE_C, ONE_C, ONE_C, -2*ONE_C));
    // overflow both ways, tiny directions, extremes of every field
    directed.insert(directed.size(), pack_ray(MIN_C, MIN_C, MIN_C, 1, 1, -1,
                    MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C));
    directed.insert(directed.size(), pack_ray(MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C,
                    MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C));
    directed.insert(directed.size(), pack_ray(MAX_C, MIN_C, 0, -1, 1, MAX_C,
                    MIN_C, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C));
    directed.insert(directed.size(), pack_ray(0, 0, 0, 1, MAX_C, MIN_C,
                    1, 1, MIN_C, 1, 1, MAX_C));
    directed.insert(directed.size(),
                    pack_ray('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    directed.insert(directed.size(), pack_ray(0, 0, 0, 3, -3, 7, 1, 1, 1, 1, 1, 1));
    foreach (directed[i]) send_beat(directed[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - QUIET_TAIL) quiet = 1;
      send_beat(rand_beat());
    end
    s_tvalid <= 0;

    waited = 0;
    while (pending != 0 && waited < 20 * IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk);

    $display("drove %0d ray/box beats with random gaps and output stalls",
             directed.size() + N_RANDOM);
    $display("checked %0d results, %0d of them hits", results_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
